// ----- rtl/right_pseudo_inverse_3xn_top_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef RIGHT_PSEUDO_INVERSE_3XN_TOP_MACROS_SVH
`define RIGHT_PSEUDO_INVERSE_3XN_TOP_MACROS_SVH
`define RPI_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RPI_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/rpi_pkg.sv -----
`default_nettype none
package rpi_pkg;
  localparam int ELEM_W = 24;
  localparam int GRAM_W = 56;
  localparam int COF_W = 2 * GRAM_W;
  localparam int PROD_W = COF_W + GRAM_W;
  localparam int ACC_W = PROD_W + 2;
  localparam int PINV_W = 32;
  localparam int NUM_JOINTS_DEF = 7;
  localparam int IN_FRAC_BITS_DEF = 12;
  localparam int OUT_FRAC_BITS_DEF = 24;

  function automatic logic [3:0] idx3(input logic [1:0] r, input logic [1:0] c);
    return {2'b00, r} * 4'd3 + {2'b00, c};
  endfunction

  function automatic logic [1:0] inc3(input logic [1:0] x);
    return (x == 2'd2) ? 2'd0 : x + 2'd1;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/rpi_ram.sv -----
`default_nettype none
module rpi_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 21
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/rpi_mul.sv -----
`default_nettype none
module rpi_mul #(
  parameter int A_W = 112,
  parameter int B_W = 56
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic signed [A_W-1:0]     a,
  input  wire logic signed [B_W-1:0]     b,
  output logic                           done,
  output logic signed [A_W+B_W-1:0]      prod
);
  localparam int P_W = A_W + B_W;

  logic           busy;
  logic           neg;
  logic [P_W-1:0] am;
  logic [B_W-1:0] bm;
  logic [P_W-1:0] acc;
  logic [A_W-1:0] a_mag;
  logic [B_W-1:0] b_mag;

  assign a_mag = a[A_W-1] ? (~a + 1'b1) : a;
  assign b_mag = b[B_W-1] ? (~b + 1'b1) : b;
  assign prod = neg ? $signed(~acc + 1'b1) : $signed(acc);

  // Shift-add over the bits of the second operand, stopping once no set bits are left.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        am   <= P_W'(a_mag);
        bm   <= b_mag;
        acc  <= '0;
        neg  <= a[A_W-1] ^ b[B_W-1];
        busy <= 1'b1;
      end else if (busy) begin
        if (bm == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          if (bm[0]) begin
            acc <= acc + am;
          end
          am <= am << 1;
          bm <= bm >> 1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/rpi_div.sv -----
`default_nettype none
module rpi_div #(
  parameter int NUM_W = 206,
  parameter int DEN_W = 170
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [NUM_W-1:0]      num,
  input  wire logic [DEN_W-1:0]      den,
  input  wire logic                  neg,
  output logic                       done,
  output logic signed [31:0]         q
);
  localparam int QB = 33;
  localparam int CW = ((NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB) + 1;
  localparam int CNT_W = $clog2(QB + 1);
  localparam logic [QB:0] LIM = (QB + 1)'(64'h8000_0000);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [CW-1:0]    rem;
  logic [CW-1:0]    dsh;
  logic [DEN_W-1:0] den_r;
  logic             neg_r;
  logic [QB-1:0]    quo;
  logic             ge;
  logic [CW:0]      rem2;
  logic             up;
  logic [QB:0]      qr;
  logic [31:0]      sat;

  assign ge = rem >= dsh;
  assign rem2 = {rem, 1'b0};
  assign up = rem2 >= (CW + 1)'(den_r);
  assign qr = {1'b0, quo} + (QB + 1)'(up);

  always_comb begin
    if (neg_r) begin
      sat = (qr >= LIM) ? 32'h8000_0000 : (~qr[31:0] + 32'd1);
    end else begin
      sat = (qr >= LIM) ? 32'h7fff_ffff : qr[31:0];
    end
  end

  // Restoring division, one quotient bit a cycle, then a final step that rounds and saturates.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem   <= CW'(num);
        dsh   <= CW'(den) << (QB - 1);
        den_r <= den;
        neg_r <= neg;
        quo   <= '0;
        cnt   <= CNT_W'(QB);
        busy  <= 1'b1;
      end else if (busy) begin
        if (cnt != '0) begin
          if (ge) begin
            rem <= rem - dsh;
          end
          quo <= {quo[QB-2:0], ge};
          dsh <= dsh >> 1;
          cnt <= cnt - 1'b1;
        end else begin
          q    <= $signed(sat);
          done <= 1'b1;
          busy <= 1'b0;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/right_pseudo_inverse_3xn_top.sv -----
// Loading takes 3*NUM_JOINTS words, one per start, and busy stays low meanwhile.
// After the last word a shared shift-add multiplier runs 18*NUM_JOINTS+21 products,
// 9*NUM_JOINTS fewer if singular, each stepping over the significant bits of its
// second operand. Each of the 3*NUM_JOINTS results is divided after its products and
// appears for one cycle on strobe; a singular matrix gives a zero result per cycle.
// Reset clears control state only; the memories hold undefined data until written.
`default_nettype none
`include "right_pseudo_inverse_3xn_top_macros.svh"
module right_pseudo_inverse_3xn_top #(
  parameter int NUM_JOINTS = rpi_pkg::NUM_JOINTS_DEF,
  parameter int IN_FRAC_BITS = rpi_pkg::IN_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS = rpi_pkg::OUT_FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic signed [rpi_pkg::ELEM_W-1:0]  elem_value,
  output logic                                    busy,
  output logic                                    strobe,
  output logic signed [rpi_pkg::PINV_W-1:0]       pinv_value,
  output logic                                    singular,
  output logic                                    is_last
);
  localparam int ELEM_W = rpi_pkg::ELEM_W;
  localparam int GRAM_W = rpi_pkg::GRAM_W;
  localparam int COF_W = rpi_pkg::COF_W;
  localparam int PROD_W = rpi_pkg::PROD_W;
  localparam int ACC_W = rpi_pkg::ACC_W;
  localparam int ELEM_CNT = 3 * NUM_JOINTS;
  localparam int JAC_AW = $clog2(ELEM_CNT);
  localparam int IDX_W = $clog2(NUM_JOINTS);
  localparam int SHIFT = IN_FRAC_BITS + OUT_FRAC_BITS;
  localparam int NUM_W = ACC_W + SHIFT;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RA   = 3'd1;
  localparam logic [2:0] S_RB   = 3'd2;
  localparam logic [2:0] S_GO   = 3'd3;
  localparam logic [2:0] S_MW   = 3'd4;
  localparam logic [2:0] S_DW   = 3'd5;
  localparam logic [2:0] S_ZERO = 3'd6;

  localparam logic [1:0] PH_GRAM = 2'd0;
  localparam logic [1:0] PH_COF  = 2'd1;
  localparam logic [1:0] PH_DET  = 2'd2;
  localparam logic [1:0] PH_NUM  = 2'd3;

  localparam logic [JAC_AW-1:0] LOAD_LAST = JAC_AW'(ELEM_CNT - 1);
  localparam logic [IDX_W-1:0] ROW_LAST = IDX_W'(NUM_JOINTS - 1);

  logic [2:0]               state;
  logic [1:0]               phase;
  logic [JAC_AW-1:0]        load_count;
  logic [IDX_W-1:0]         row;
  logic [1:0]               col;
  logic [IDX_W-1:0]         term;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  det;
  logic signed [COF_W-1:0]  opa;
  logic signed [GRAM_W-1:0] opb;

  logic [JAC_AW-1:0] jac_raddr;
  logic [ELEM_W-1:0] jac_rdata;
  logic              jac_we;
  logic [3:0]        gram_raddr;
  logic [GRAM_W-1:0] gram_rdata;
  logic              gram_we;
  logic [3:0]        cof_raddr;
  logic [COF_W-1:0]  cof_rdata;
  logic              cof_we;
  logic [3:0]        wr_idx;

  logic                     mul_start;
  logic                     mul_done;
  logic signed [PROD_W-1:0] mul_prod;
  logic                     div_start;
  logic                     div_done;
  logic signed [31:0]       div_q;

  logic [1:0]              r1, r2, c1, c2;
  logic                    term_last;
  logic                    step_end;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] acc_sum;
  logic [ACC_W-1:0]        acc_mag;
  logic [ACC_W-1:0]        det_mag;
  logic                    last33;
  logic                    last_out;

  assign busy = (state != S_IDLE);
  assign r1 = rpi_pkg::inc3(row[1:0]);
  assign r2 = rpi_pkg::inc3(r1);
  assign c1 = rpi_pkg::inc3(col);
  assign c2 = rpi_pkg::inc3(c1);
  assign wr_idx = rpi_pkg::idx3(row[1:0], col);
  assign last33 = (row[1:0] == 2'd2) && (col == 2'd2);
  assign last_out = (row == ROW_LAST) && (col == 2'd2);

  always_comb begin
    case (phase)
      PH_GRAM: term_last = (term == ROW_LAST);
      PH_COF:  term_last = (term == IDX_W'(1));
      default: term_last = (term == IDX_W'(2));
    endcase
  end

  always_comb begin
    if (state == S_RA) begin
      jac_raddr = JAC_AW'(int'(row) * NUM_JOINTS + int'(term));
      gram_raddr = (term == '0) ? rpi_pkg::idx3(r1, c1) : rpi_pkg::idx3(r1, c2);
      cof_raddr = (phase == PH_DET) ? 4'(term) : rpi_pkg::idx3(term[1:0], col);
    end else begin
      jac_raddr = (phase == PH_GRAM) ? JAC_AW'(int'(col) * NUM_JOINTS + int'(term))
                                     : JAC_AW'(int'(term) * NUM_JOINTS + int'(row));
      gram_raddr = (phase == PH_DET) ? 4'(term)
                 : ((term == '0) ? rpi_pkg::idx3(r2, c2) : rpi_pkg::idx3(r2, c1));
      cof_raddr = 4'(term);
    end
  end

  assign prod_ext = ACC_W'(mul_prod);
  assign acc_sum = ((phase == PH_COF) && (term != '0)) ? acc - prod_ext : acc + prod_ext;
  assign acc_mag = acc_sum[ACC_W-1] ? (~acc_sum + 1'b1) : acc_sum;
  assign det_mag = det[ACC_W-1] ? (~det + 1'b1) : det;
  assign step_end = (state == S_MW) && mul_done && term_last;

  assign jac_we = (state == S_IDLE) && start;
  assign gram_we = step_end && (phase == PH_GRAM);
  assign cof_we = step_end && (phase == PH_COF);
  assign mul_start = (state == S_GO);
  assign div_start = step_end && (phase == PH_NUM);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= PH_GRAM;
      load_count <= '0;
      strobe     <= 1'b0;
      is_last    <= 1'b0;
    end else begin
      strobe  <= 1'b0;
      is_last <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            if (load_count == LOAD_LAST) begin
              load_count <= '0;
              state      <= S_RA;
              phase      <= PH_GRAM;
              row        <= '0;
              col        <= '0;
              term       <= '0;
              acc        <= '0;
            end else begin
              load_count <= load_count + 1'b1;
            end
          end
        end
        S_RA: begin
          state <= S_RB;
        end
        S_RB: begin
          case (phase)
            PH_GRAM: opa <= COF_W'($signed(jac_rdata));
            PH_COF:  opa <= COF_W'($signed(gram_rdata));
            default: opa <= $signed(cof_rdata);
          endcase
          state <= S_GO;
        end
        S_GO: begin
          state <= S_MW;
        end
        S_MW: begin
          if (mul_done) begin
            if (!term_last) begin
              acc   <= acc_sum;
              term  <= term + 1'b1;
              state <= S_RA;
            end else begin
              acc  <= '0;
              term <= '0;
              case (phase)
                PH_GRAM, PH_COF: begin
                  state <= S_RA;
                  if (last33) begin
                    row   <= '0;
                    col   <= '0;
                    phase <= (phase == PH_GRAM) ? PH_COF : PH_DET;
                  end else if (col == 2'd2) begin
                    col <= '0;
                    row <= row + 1'b1;
                  end else begin
                    col <= col + 1'b1;
                  end
                end
                PH_DET: begin
                  det   <= acc_sum;
                  row   <= '0;
                  col   <= '0;
                  phase <= PH_NUM;
                  state <= (acc_sum == '0) ? S_ZERO : S_RA;
                end
                default: begin
                  state <= S_DW;
                end
              endcase
            end
          end
        end
        S_DW, S_ZERO: begin
          if ((state == S_ZERO) || div_done) begin
            strobe     <= 1'b1;
            pinv_value <= (state == S_ZERO) ? '0 : div_q;
            singular   <= (state == S_ZERO);
            is_last    <= last_out;
            if (last_out) begin
              state <= S_IDLE;
            end else begin
              if (state == S_DW) begin
                state <= S_RA;
              end
              if (col == 2'd2) begin
                col <= '0;
                row <= row + 1'b1;
              end else begin
                col <= col + 1'b1;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    if ((phase == PH_GRAM) || (phase == PH_NUM)) begin
      opb = GRAM_W'($signed(jac_rdata));
    end else begin
      opb = $signed(gram_rdata);
    end
  end

  rpi_ram #(.WIDTH(ELEM_W), .DEPTH(ELEM_CNT)) u_jac (
    .clk   (clk),
    .we    (jac_we),
    .waddr (load_count),
    .wdata (elem_value),
    .raddr (jac_raddr),
    .rdata (jac_rdata)
  );

  rpi_ram #(.WIDTH(GRAM_W), .DEPTH(9)) u_gram (
    .clk   (clk),
    .we    (gram_we),
    .waddr (wr_idx),
    .wdata (acc_sum[GRAM_W-1:0]),
    .raddr (gram_raddr),
    .rdata (gram_rdata)
  );

  rpi_ram #(.WIDTH(COF_W), .DEPTH(9)) u_cof (
    .clk   (clk),
    .we    (cof_we),
    .waddr (wr_idx),
    .wdata (acc_sum[COF_W-1:0]),
    .raddr (cof_raddr),
    .rdata (cof_rdata)
  );

  rpi_mul #(.A_W(COF_W), .B_W(GRAM_W)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (opa),
    .b     (opb),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  rpi_div #(.NUM_W(NUM_W), .DEN_W(ACC_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({acc_mag, {SHIFT{1'b0}}}),
    .den   (det_mag),
    .neg   (acc_sum[ACC_W-1] ^ det[ACC_W-1]),
    .done  (div_done),
    .q     (div_q)
  );

  `RPI_ASSERT_IMP(a_last_has_strobe, is_last, strobe)
  `RPI_ASSERT_IMP(a_singular_zero, strobe && singular, pinv_value == '0)
  `RPI_ASSERT_IMP(a_last_frees_block, is_last, !busy)
  `RPI_ASSERT_NXT(a_full_load_busy, start && !busy && (load_count == LOAD_LAST), busy)
endmodule
`default_nettype wire
